/* hdl/fftc_pkg.sv */
package fftc_pkg;

   // Default coordinate width and register reset values
   localparam int COORD_BITS_DEF = 15;
   localparam int MODULUS_RESET  = 5;
   localparam int Q_RESET        = 0;

   // Cycles through one modular multiply unit
   localparam int MM_LATENCY = 4;

   // Register map of the configuration port
   localparam int CSR_INDEX_BITS = 2;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_MODULUS = 2'd0;
   localparam csr_index_type CSR_Q_VALUE = 2'd1;

   // Line pairs tried for the intersection, in order
   typedef logic [1:0] line_index_type;
   localparam line_index_type PAIR_A [3] = '{2'd0, 2'd0, 2'd1};
   localparam line_index_type PAIR_B [3] = '{2'd1, 2'd2, 2'd2};

endpackage

/* hdl/fftc_modmul.sv */
module fftc_modmul #(
   parameter int COORD_BITS = 15
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [COORD_BITS-1:0]   a,
   input  logic [COORD_BITS-1:0]   b,
   input  logic [COORD_BITS-1:0]   p,
   input  logic [2*COORD_BITS:0]   m,
   output logic [COORD_BITS-1:0]   r
);
   localparam int W = COORD_BITS;
   localparam int K = 2 * W;

   logic [K-1:0]   prod_in, prod_ff;
   logic [K-1:0]   prod2_ff;
   logic [2*K:0]   bar_full;
   logic [K-1:0]   qhat_in, qhat_ff;
   logic [K-1:0]   qp;
   logic [K-1:0]   diff;
   logic [W:0]     rem_in, rem_ff;
   logic [W:0]     rem_sub;
   logic [W-1:0]   out_in, out_ff;

   assign prod_in  = {{W{1'b0}}, a} * {{W{1'b0}}, b};
   // Barrett estimate of the quotient, low by at most one
   assign bar_full = {{(K+1){1'b0}}, prod_ff} * {{K{1'b0}}, m};
   assign qhat_in  = bar_full[2*K-1:K];
   assign qp       = qhat_ff * {{W{1'b0}}, p};
   assign diff     = prod2_ff - qp;
   assign rem_in   = diff[W:0];
   assign rem_sub  = rem_ff - {1'b0, p};
   assign out_in   = (rem_ff >= {1'b0, p}) ? rem_sub[W-1:0] : rem_ff[W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         qhat_ff  <= qhat_in;
         prod2_ff <= prod_ff;
         rem_ff   <= rem_in;
         out_ff   <= out_in;
      end
   end

   assign r = out_ff;
endmodule

/* hdl/fftc_recip.sv */
module fftc_recip #(
   parameter int COORD_BITS = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [COORD_BITS-1:0]   divisor,
   output logic                    busy,
   output logic [2*COORD_BITS:0]   quot
);
   import fftc_pkg::*;

   localparam int W  = COORD_BITS;
   localparam int K  = 2 * W;
   localparam int CW = $clog2(K + 1);
   localparam logic [K:0] QUOT_RESET = (K+1)'((64'd1 << K) / 64'(MODULUS_RESET));

   logic            busy_ff, busy_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    dvs_ff, dvs_in;
   logic [K:0]      quo_ff, quo_in;
   logic [W:0]      trial;
   logic [W:0]      trial_sub;
   logic            ge;

   // Long division of 2^K by the divisor, one quotient bit a cycle
   assign trial     = {rem_ff, (cnt_ff == CW'(K))};
   assign ge        = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(K);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? trial_sub[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[K-1:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         quo_ff  <= QUOT_RESET;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         quo_ff  <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;
endmodule

/* hdl/finite_field_triangle_circle_check.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_mid0_x .. req_dir2_y
// rsp      out        rsp_valid/rsp_stall  rsp_accepted, rsp_all_parallel
// csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One transaction a cycle while req_stall is low. The pipeline has six modular
// multiply levels of four stages each (product, Barrett estimate, subtract,
// correct) plus the output. A modulus write recomputes the Barrett reciprocal;
// req_stall is high and csr_ready low while it runs. Reset is synchronous and
// loads modulus 5 and its reciprocal directly. A result arriving during an
// output stall parks in a skid register; the pipeline halts while it is full.
module finite_field_triangle_circle_check #(
   parameter int COORD_BITS = fftc_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_BITS-1:0]         req_mid0_x,
   input  logic [COORD_BITS-1:0]         req_mid0_y,
   input  logic [COORD_BITS-1:0]         req_mid1_x,
   input  logic [COORD_BITS-1:0]         req_mid1_y,
   input  logic [COORD_BITS-1:0]         req_mid2_x,
   input  logic [COORD_BITS-1:0]         req_mid2_y,
   input  logic [COORD_BITS-1:0]         req_dir0_x,
   input  logic [COORD_BITS-1:0]         req_dir0_y,
   input  logic [COORD_BITS-1:0]         req_dir1_x,
   input  logic [COORD_BITS-1:0]         req_dir1_y,
   input  logic [COORD_BITS-1:0]         req_dir2_x,
   input  logic [COORD_BITS-1:0]         req_dir2_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic                          rsp_all_parallel,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  fftc_pkg::csr_index_type       csr_index,
   input  logic [COORD_BITS-1:0]         csr_wdata
);
   import fftc_pkg::*;

   localparam int W   = COORD_BITS;
   localparam int K   = 2 * W;
   localparam int LVL = MM_LATENCY;
   localparam int LAT = 6 * LVL;

   typedef logic [W-1:0] res_type;
   typedef logic [W+1:0] wide_type;

   typedef struct packed {
      res_type [2:0] mx;
      res_type [2:0] my;
      res_type [2:0] l0;
      res_type [2:0] l1;
      res_type       q;
   } carry_b_type;

   typedef struct packed {
      logic          degen;
      res_type       den;
      res_type       fac;
      res_type [2:0] mx;
      res_type [2:0] my;
      res_type [2:0] l0;
      res_type [2:0] l1;
      res_type [2:0] l2;
   } carry_c_type;

   typedef struct packed {
      logic    degen;
      res_type fac;
      res_type ox;
      res_type oy;
   } carry_d_type;

   typedef struct packed {
      logic          degen;
      logic          on_ok;
      res_type       fac;
      res_type [2:0] rhs;
   } carry_e_type;

   typedef struct packed {
      logic          degen;
      logic          on_ok;
      res_type [2:0] rhs;
   } carry_f_type;

   function automatic res_type f_sub(res_type a, res_type b, res_type p);
      logic [W:0] t;
      t = {1'b0, a} - {1'b0, b};
      if (a < b) begin
         t = t + {1'b0, p};
      end
      return t[W-1:0];
   endfunction

   // Reduce a value below 4p
   function automatic res_type f_red4(wide_type x, res_type p);
      wide_type p1;
      wide_type p2;
      wide_type t;
      p1 = {2'b00, p};
      p2 = {1'b0, p, 1'b0};
      t  = x;
      if (t >= p2) begin
         t = t - p2;
      end
      if (t >= p1) begin
         t = t - p1;
      end
      return t[W-1:0];
   endfunction

   function automatic wide_type f_w(res_type a);
      return {2'b00, a};
   endfunction

   // x^2 + 3y^2 from the two squares
   function automatic res_type f_norm(res_type xx, res_type yy, res_type p);
      return f_red4(f_w(xx) + f_w(yy) + {1'b0, yy, 1'b0}, p);
   endfunction

   // ---------------------------------------------------------------- config
   logic          csr_wr;
   logic          rcp_start;
   logic          rcp_busy;
   logic [K:0]    rcp_quot;
   res_type       p_ff, p_in;
   res_type       q_ff, q_in;

   assign csr_wr    = csr_valid && csr_ready;
   assign rcp_start = csr_wr && (csr_index == CSR_MODULUS);

   always_comb begin
      p_in = p_ff;
      q_in = q_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_MODULUS: begin
               p_in = (csr_wdata == '0) ? W'(1) : csr_wdata;
            end
            CSR_Q_VALUE: begin
               q_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= W'(MODULUS_RESET);
         q_ff <= W'(Q_RESET);
      end else begin
         p_ff <= p_in;
         q_ff <= q_in;
      end
   end

   fftc_recip #(.COORD_BITS(W)) u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (rcp_start),
      .divisor (p_in),
      .busy    (rcp_busy),
      .quot    (rcp_quot)
   );

   assign csr_ready = !rcp_busy;

   // ------------------------------------------------------ pipeline control
   logic adv;
   logic vld_ff [LAT];
   logic skid_valid_ff, skid_valid_in;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff || rcp_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid && !req_stall;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // --------------------------------------------- level A: reduce the inputs
   res_type a_a [13];
   res_type r_a [13];

   assign a_a[0]  = req_mid0_x;
   assign a_a[1]  = req_mid0_y;
   assign a_a[2]  = req_mid1_x;
   assign a_a[3]  = req_mid1_y;
   assign a_a[4]  = req_mid2_x;
   assign a_a[5]  = req_mid2_y;
   assign a_a[6]  = req_dir0_x;
   assign a_a[7]  = req_dir0_y;
   assign a_a[8]  = req_dir1_x;
   assign a_a[9]  = req_dir1_y;
   assign a_a[10] = req_dir2_x;
   assign a_a[11] = req_dir2_y;
   assign a_a[12] = q_ff;

   for (genvar g = 0; g < 13; g++) begin : g_lvl_a
      fftc_modmul #(.COORD_BITS(W)) u_mm (
         .clock (clock), .en (adv), .a (a_a[g]), .b (W'(1)),
         .p (p_ff), .m (rcp_quot), .r (r_a[g])
      );
   end

   // ------------------------------- level B: line terms, squares, determinants
   res_type     a_b [20];
   res_type     b_b [20];
   res_type     r_b [20];
   carry_b_type cb_in;
   carry_b_type cb_ff [LVL];
   carry_b_type cbo;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cb_in.mx[i] = r_a[2*i];
         cb_in.my[i] = r_a[2*i+1];
         cb_in.l0[i] = f_sub('0, r_a[7+2*i], p_ff);
         cb_in.l1[i] = r_a[6+2*i];
      end
      cb_in.q = r_a[12];
      for (int i = 0; i < 3; i++) begin
         a_b[i]    = r_a[7+2*i];
         b_b[i]    = r_a[2*i];
         a_b[3+i]  = r_a[6+2*i];
         b_b[3+i]  = r_a[2*i+1];
         a_b[6+i]  = r_a[6+2*i];
         b_b[6+i]  = r_a[6+2*i];
         a_b[9+i]  = r_a[7+2*i];
         b_b[9+i]  = r_a[7+2*i];
      end
      a_b[12] = f_sub(r_a[2], r_a[0], p_ff);
      b_b[12] = a_b[12];
      a_b[13] = f_sub(r_a[3], r_a[1], p_ff);
      b_b[13] = a_b[13];
      for (int k = 0; k < 3; k++) begin
         a_b[14+k] = cb_in.l0[PAIR_A[k]];
         b_b[14+k] = cb_in.l1[PAIR_B[k]];
         a_b[17+k] = cb_in.l0[PAIR_B[k]];
         b_b[17+k] = cb_in.l1[PAIR_A[k]];
      end
   end

   for (genvar g = 0; g < 20; g++) begin : g_lvl_b
      fftc_modmul #(.COORD_BITS(W)) u_mm (
         .clock (clock), .en (adv), .a (a_b[g]), .b (b_b[g]),
         .p (p_ff), .m (rcp_quot), .r (r_b[g])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cb_ff[0] <= cb_in;
         for (int i = 1; i < LVL; i++) begin
            cb_ff[i] <= cb_ff[i-1];
         end
      end
   end
   assign cbo = cb_ff[LVL-1];

   // ---------------------------------- level C: choose pair, intersection terms
   res_type        det [3];
   res_type        nd [3];
   res_type        l2 [3];
   res_type        side;
   res_type        q4;
   line_index_type sel;
   logic           degen;
   res_type        a_c [8];
   res_type        b_c [8];
   res_type        r_c [8];
   carry_c_type    cc_in;
   carry_c_type    cc_ff [LVL];
   carry_c_type    cco;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         det[k] = f_sub(r_b[14+k], r_b[17+k], p_ff);
         nd[k]  = f_norm(r_b[6+k], r_b[9+k], p_ff);
         l2[k]  = f_sub(r_b[k], r_b[3+k], p_ff);
      end
      side  = f_norm(r_b[12], r_b[13], p_ff);
      q4    = f_red4({cbo.q, 2'b00}, p_ff);
      degen = 1'b0;
      sel   = 2'd0;
      priority if (det[0] != '0) begin
         sel = 2'd0;
      end else if (det[1] != '0) begin
         sel = 2'd1;
      end else if (det[2] != '0) begin
         sel = 2'd2;
      end else begin
         degen = 1'b1;
      end

      cc_in.degen = degen;
      cc_in.den   = degen ? '0 : det[sel];
      cc_in.fac   = f_red4({f_sub(cbo.q, side, p_ff), 2'b00}, p_ff);
      cc_in.mx    = cbo.mx;
      cc_in.my    = cbo.my;
      cc_in.l0    = cbo.l0;
      cc_in.l1    = cbo.l1;
      for (int k = 0; k < 3; k++) begin
         cc_in.l2[k] = l2[k];
      end

      // ox = a1*b2 - b1*a2, oy = a2*b0 - b2*a0
      a_c[0] = cbo.l1[PAIR_A[sel]];
      b_c[0] = l2[PAIR_B[sel]];
      a_c[1] = cbo.l1[PAIR_B[sel]];
      b_c[1] = l2[PAIR_A[sel]];
      a_c[2] = l2[PAIR_A[sel]];
      b_c[2] = cbo.l0[PAIR_B[sel]];
      a_c[3] = l2[PAIR_B[sel]];
      b_c[3] = cbo.l0[PAIR_A[sel]];
      for (int i = 0; i < 3; i++) begin
         a_c[4+i] = side;
         b_c[4+i] = f_sub(q4, nd[i], p_ff);
      end
      a_c[7] = cc_in.den;
      b_c[7] = cc_in.den;
   end

   for (genvar g = 0; g < 8; g++) begin : g_lvl_c
      fftc_modmul #(.COORD_BITS(W)) u_mm (
         .clock (clock), .en (adv), .a (a_c[g]), .b (b_c[g]),
         .p (p_ff), .m (rcp_quot), .r (r_c[g])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cc_ff[0] <= cc_in;
         for (int i = 1; i < LVL; i++) begin
            cc_ff[i] <= cc_ff[i-1];
         end
      end
   end
   assign cco = cc_ff[LVL-1];

   // ------------------------------- level D: incidence, offsets, right side
   res_type     ox;
   res_type     oy;
   res_type     a_d [18];
   res_type     b_d [18];
   res_type     r_d [18];
   carry_d_type cd_in;
   carry_d_type cd_ff [LVL];
   carry_d_type cdo;

   assign ox = f_sub(r_c[0], r_c[1], p_ff);
   assign oy = f_sub(r_c[2], r_c[3], p_ff);

   always_comb begin
      cd_in.degen = cco.degen;
      cd_in.fac   = cco.fac;
      cd_in.ox    = ox;
      cd_in.oy    = oy;
      for (int i = 0; i < 3; i++) begin
         a_d[i]    = cco.l0[i];
         b_d[i]    = ox;
         a_d[3+i]  = cco.l1[i];
         b_d[3+i]  = oy;
         a_d[6+i]  = cco.l2[i];
         b_d[6+i]  = cco.den;
         a_d[9+i]  = cco.mx[i];
         b_d[9+i]  = cco.den;
         a_d[12+i] = cco.my[i];
         b_d[12+i] = cco.den;
         a_d[15+i] = r_c[4+i];
         b_d[15+i] = r_c[7];
      end
   end

   for (genvar g = 0; g < 18; g++) begin : g_lvl_d
      fftc_modmul #(.COORD_BITS(W)) u_mm (
         .clock (clock), .en (adv), .a (a_d[g]), .b (b_d[g]),
         .p (p_ff), .m (rcp_quot), .r (r_d[g])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff[0] <= cd_in;
         for (int i = 1; i < LVL; i++) begin
            cd_ff[i] <= cd_ff[i-1];
         end
      end
   end
   assign cdo = cd_ff[LVL-1];

   // ------------------------------------------ level E: squares of offsets
   res_type     a_e [6];
   res_type     r_e [6];
   carry_e_type ce_in;
   carry_e_type ce_ff [LVL];
   carry_e_type ceo;

   always_comb begin
      ce_in.degen = cdo.degen;
      ce_in.fac   = cdo.fac;
      ce_in.on_ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (f_red4(f_w(r_d[i]) + f_w(r_d[3+i]) + f_w(r_d[6+i]), p_ff) != '0) begin
            ce_in.on_ok = 1'b0;
         end
         ce_in.rhs[i] = r_d[15+i];
         a_e[i]       = f_sub(r_d[9+i], cdo.ox, p_ff);
         a_e[3+i]     = f_sub(r_d[12+i], cdo.oy, p_ff);
      end
   end

   for (genvar g = 0; g < 6; g++) begin : g_lvl_e
      fftc_modmul #(.COORD_BITS(W)) u_mm (
         .clock (clock), .en (adv), .a (a_e[g]), .b (a_e[g]),
         .p (p_ff), .m (rcp_quot), .r (r_e[g])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ce_ff[0] <= ce_in;
         for (int i = 1; i < LVL; i++) begin
            ce_ff[i] <= ce_ff[i-1];
         end
      end
   end
   assign ceo = ce_ff[LVL-1];

   // -------------------------------------------------- level F: left side
   res_type     a_f [3];
   res_type     r_f [3];
   carry_f_type cf_in;
   carry_f_type cf_ff [LVL];
   carry_f_type cfo;

   always_comb begin
      cf_in.degen = ceo.degen;
      cf_in.on_ok = ceo.on_ok;
      cf_in.rhs   = ceo.rhs;
      for (int i = 0; i < 3; i++) begin
         a_f[i] = f_norm(r_e[i], r_e[3+i], p_ff);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lvl_f
      fftc_modmul #(.COORD_BITS(W)) u_mm (
         .clock (clock), .en (adv), .a (a_f[g]), .b (ceo.fac),
         .p (p_ff), .m (rcp_quot), .r (r_f[g])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cf_ff[0] <= cf_in;
         for (int i = 1; i < LVL; i++) begin
            cf_ff[i] <= cf_ff[i-1];
         end
      end
   end
   assign cfo = cf_ff[LVL-1];

   // ---------------------------------------------- verdict and output skid
   logic fin_valid;
   logic fin_acc;
   logic fin_par;
   logic out_valid_ff, out_valid_in;
   logic out_acc_ff, out_acc_in;
   logic out_par_ff, out_par_in;
   logic skid_acc_ff, skid_acc_in;
   logic skid_par_ff, skid_par_in;

   assign fin_valid = vld_ff[LAT-1];
   assign fin_par   = cfo.degen;
   assign fin_acc   = cfo.degen || (cfo.on_ok && (r_f[0] == cfo.rhs[0])
                      && (r_f[1] == cfo.rhs[1]) && (r_f[2] == cfo.rhs[2]));

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_acc_in    = out_acc_ff;
      out_par_in    = out_par_ff;
      skid_valid_in = skid_valid_ff;
      skid_acc_in   = skid_acc_ff;
      skid_par_in   = skid_par_ff;
      if (out_valid_ff && rsp_stall) begin
         // hold the output; park an arriving transaction in the skid
         if (adv && fin_valid) begin
            skid_valid_in = 1'b1;
            skid_acc_in   = fin_acc;
            skid_par_in   = fin_par;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_acc_in    = skid_acc_ff;
         out_par_in    = skid_par_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = fin_valid;
         out_acc_in   = fin_acc;
         out_par_in   = fin_par;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_acc_ff  <= out_acc_in;
      out_par_ff  <= out_par_in;
      skid_acc_ff <= skid_acc_in;
      skid_par_ff <= skid_par_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_accepted     = out_acc_ff;
   assign rsp_all_parallel = out_par_ff;

   // ------------------------------------------------------------ assertions
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while the output is empty");

   a_modulus_starts_recip: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == CSR_MODULUS)) |=> rcp_busy)
      else $error("modulus write did not start the reciprocal");

   a_degen_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_all_parallel) |-> rsp_accepted)
      else $error("degenerate transaction not accepted");

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      rcp_busy |-> req_stall)
      else $error("request taken while the reciprocal is computed");

   a_modulus_nonzero: assert property (@(posedge clock) disable iff (reset)
      p_ff != '0)
      else $error("zero modulus stored");
endmodule
